### src/eegpp_pkg.sv
// shared types and constants for the headset packet parser with motor drive
package eegpp_pkg;

    // framing
    localparam logic [7:0] SYNC_BYTE    = 8'hAA;
    localparam logic [7:0] MAX_PAYLOAD  = 8'd169;

    // payload codes
    localparam logic [7:0] CODE_QUAL    = 8'h02;
    localparam logic [7:0] CODE_ATT     = 8'h04;
    localparam logic [7:0] CODE_MED     = 8'h05;
    localparam logic [7:0] CODE_SKIP_S  = 8'h80;
    localparam logic [7:0] CODE_SKIP_L  = 8'h83;

    // skip lengths for the two skip codes
    localparam logic [4:0] SKIP_SHORT   = 5'd3;
    localparam logic [4:0] SKIP_LONG    = 5'd25;

    // per-packet defaults
    localparam logic [7:0] QUAL_DEFAULT = 8'd200;
    localparam logic [7:0] ATT_MAX      = 8'd100;

    // x / 100 as (x * 5243) >> 19, exact for x up to 25500
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // parser phases, one-hot
    typedef enum logic [4:0] {
        PH_SYNC1   = 5'b00001,
        PH_SYNC2   = 5'b00010,
        PH_LEN     = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_CHECK   = 5'b10000
    } phase_t;

    // value byte expected next
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_QUAL = 2'd1,
        PEND_ATT  = 2'd2,
        PEND_MED  = 2'd3
    } pend_t;

endpackage

### src/eegpp_rx_if.sv
// request channel carrying one received serial byte
interface eegpp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### src/eegpp_res_if.sv
// result channel carrying the decoded packet and motor drive state
interface eegpp_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] signal_quality;
    logic [7:0] attention_level;
    logic [7:0] meditation_level;
    logic       motor_update;
    logic [8:0] pwm_duty;
    logic       wire_a;
    logic       wire_b;

    modport source (
        output valid, output signal_quality, output attention_level,
        output meditation_level, output motor_update, output pwm_duty,
        output wire_a, output wire_b, input ready
    );
    modport sink (
        input valid, input signal_quality, input attention_level,
        input meditation_level, input motor_update, input pwm_duty,
        input wire_a, input wire_b, output ready
    );
endinterface

### src/eegpp_cfg_if.sv
// configuration write channel for the motor direction register
interface eegpp_cfg_if;
    logic valid;
    logic ready;
    logic motor_direction;

    modport source (output valid, output motor_direction, input ready);
    modport sink (input valid, input motor_direction, output ready);
endinterface

### src/eeg_packet_parser_motor_drive_top.sv
// Headset packet parser with motor drive: top level
//
// rx carries one serial byte per request. The parser hunts two 0xAA sync
// bytes, reads a length, decodes the payload codes on the fly and checks the
// trailing checksum byte. Each packet with a good checksum yields one request
// on res: quality, attention, meditation, the drive update flag, the PWM duty
// and the two motor wire levels.
// cfg writes the one-bit motor direction; it is always ready and should only
// be written while no packet is in flight.
// Throughput: one byte per cycle while rx is not stalled, set by the single
// register stage of the parser state. The result appears in the cycle after
// the checksum byte is taken and stays until res.ready.
// Stall: a held result only blocks rx when the next byte is a checksum byte;
// all other bytes keep flowing.
// Reset: rst_n clears the parser to sync hunting, the wires to low and the
// direction register to 1.
module eeg_packet_parser_motor_drive_top
    import eegpp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    eegpp_rx_if.sink     rx,
    eegpp_res_if.source  res,
    eegpp_cfg_if.sink    cfg
);

    phase_t      phase_reg, phase_next;
    pend_t       pend_reg, pend_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  sum_reg, sum_next;
    logic [4:0]  skip_reg, skip_next;
    logic [7:0]  qual_reg, qual_next;
    logic [7:0]  att_reg, att_next;
    logic [7:0]  med_reg, med_next;
    logic        drive_reg, drive_next;
    logic [1:0]  wires_reg, wires_next;
    logic        dir_reg;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_qual_reg, out_att_reg, out_med_reg;
    logic        out_upd_reg;
    logic [8:0]  out_duty_reg;
    logic        emit;

    logic        rx_fire;
    logic [7:0]  b;
    logic [7:0]  idx_inc;
    logic [15:0] att_x255;
    logic [28:0] att_prod;
    logic [7:0]  speed;
    logic [9:0]  speed_x3;
    logic [8:0]  duty;
    logic        att_ok;

    // only a checksum byte can create a result, so only it waits on the output
    assign rx.ready = !out_valid_reg || res.ready || (phase_reg != PH_CHECK);
    assign rx_fire  = rx.valid && rx.ready;
    assign b        = rx.rx_byte;
    assign idx_inc  = idx_reg + 8'd1;
    assign cfg.ready = 1'b1;

    // speed = attention * 255 / 100, duty = speed * 3 / 2
    assign att_x255 = {att_reg, 8'd0} - {8'd0, att_reg};
    assign att_prod = {13'd0, att_x255} * {16'd0, RECIP_100};
    assign speed    = att_prod[RECIP_SHIFT +: 8];
    assign speed_x3 = {2'd0, speed} + {1'b0, speed, 1'b0};
    assign duty     = speed_x3[9:1];
    assign att_ok   = (att_reg != 8'd0) && (att_reg <= ATT_MAX);

    // parser next state
    always_comb
    begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        skip_next  = skip_reg;
        qual_next  = qual_reg;
        att_next   = att_reg;
        med_next   = med_reg;
        drive_next = drive_reg;
        wires_next = wires_reg;
        emit       = 1'b0;
        if (rx_fire)
        begin
            case (phase_reg)
                PH_SYNC1:
                begin
                    if (b == SYNC_BYTE)
                        phase_next = PH_SYNC2;
                end
                PH_SYNC2:
                begin
                    phase_next = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
                end
                PH_LEN:
                begin
                    if (b > MAX_PAYLOAD)
                    begin
                        phase_next = PH_SYNC1;
                    end
                    else
                    begin
                        len_next   = b;
                        idx_next   = 8'd0;
                        sum_next   = 8'd0;
                        skip_next  = 5'd0;
                        pend_next  = PEND_NONE;
                        qual_next  = QUAL_DEFAULT;
                        att_next   = 8'd0;
                        med_next   = 8'd0;
                        drive_next = 1'b0;
                        phase_next = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    sum_next = sum_reg + b;
                    idx_next = idx_inc;
                    if (idx_inc >= len_reg)
                        phase_next = PH_CHECK;
                    if (skip_reg != 5'd0)
                    begin
                        skip_next = skip_reg - 5'd1;
                    end
                    else
                    begin
                        case (pend_reg)
                            PEND_QUAL:
                            begin
                                qual_next  = b;
                                drive_next = 1'b1;
                                pend_next  = PEND_NONE;
                            end
                            PEND_ATT:
                            begin
                                att_next  = b;
                                pend_next = PEND_NONE;
                            end
                            PEND_MED:
                            begin
                                med_next  = b;
                                pend_next = PEND_NONE;
                            end
                            default:
                            begin
                                // code byte
                                if (b == CODE_QUAL)
                                    pend_next = PEND_QUAL;
                                else if (b == CODE_ATT)
                                    pend_next = PEND_ATT;
                                else if (b == CODE_MED)
                                    pend_next = PEND_MED;
                                else if (b == CODE_SKIP_S)
                                    skip_next = SKIP_SHORT;
                                else if (b == CODE_SKIP_L)
                                    skip_next = SKIP_LONG;
                            end
                        endcase
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_SYNC1;
                    if (b == ~sum_reg)
                    begin
                        emit       = 1'b1;
                        drive_next = 1'b0;
                        if (drive_reg && att_ok)
                            wires_next = dir_reg ? 2'b01 : 2'b10;
                    end
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    // result handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.ready)
            out_valid_next = 1'b0;
        if (emit)
            out_valid_next = 1'b1;
    end

    // control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC1;
            pend_reg      <= PEND_NONE;
            len_reg       <= 8'd0;
            idx_reg       <= 8'd0;
            sum_reg       <= 8'd0;
            skip_reg      <= 5'd0;
            qual_reg      <= QUAL_DEFAULT;
            att_reg       <= 8'd0;
            med_reg       <= 8'd0;
            drive_reg     <= 1'b0;
            wires_reg     <= 2'b00;
            dir_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pend_reg      <= pend_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            skip_reg      <= skip_next;
            qual_reg      <= qual_next;
            att_reg       <= att_next;
            med_reg       <= med_next;
            drive_reg     <= drive_next;
            wires_reg     <= wires_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                dir_reg <= cfg.motor_direction;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_qual_reg <= qual_reg;
            out_att_reg  <= att_reg;
            out_med_reg  <= med_reg;
            out_upd_reg  <= drive_reg;
            out_duty_reg <= (drive_reg && att_ok) ? duty : 9'd0;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.signal_quality   = out_qual_reg;
    assign res.attention_level  = out_att_reg;
    assign res.meditation_level = out_med_reg;
    assign res.motor_update     = out_upd_reg;
    assign res.pwm_duty         = out_duty_reg;
    assign res.wire_a           = wires_reg[0];
    assign res.wire_b           = wires_reg[1];

    // a result only follows a checksum byte
    a_emit_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(phase_reg == PH_CHECK))
        else $error("result without checksum byte");

    // rx only stalls on a checksum byte behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> (out_valid_reg && phase_reg == PH_CHECK))
        else $error("rx stalled without a pending result");

    // index stays inside the payload
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (idx_reg < len_reg))
        else $error("payload index past length");

    // nonzero duty only with a drive update
    a_duty_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_duty_reg != 9'd0) |-> out_upd_reg)
        else $error("duty without drive update");

    // skip count never above the long skip
    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg <= SKIP_LONG)
        else $error("skip count out of range");

endmodule
